// File: sv/ncq_pkg.sv
// Shared constants and types of the Newton-Cotes quadrature core.
package ncq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int ACC_WIDTH_DEF    = 64;
    localparam int OUT_WIDTH        = 64;
    localparam int RULE_W           = 2;
    localparam int STEP_W           = 32;
    localparam int LIMB_W           = 32;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 32;
    localparam int FIFO_DEPTH       = 4;
    // Boole weights times 360 reach 1440 times a sample, so twelve bits of growth.
    localparam int WSUM_GROWTH      = 12;
    localparam int SCALE_DEN        = 360;
    localparam int HALF_DEN         = 180;
    localparam int REM_W            = 9;
    // one quotient digit of the division by 360 per cycle: a digit step sees less than
    // 360 * 2^16, so its product with ceil(2^34 / 360) shifted down by 34 is exact
    localparam int DIV_DIGIT_W      = 16;
    localparam int RECIP_SHIFT      = 34;
    localparam int RECIP_W          = 26;
    localparam logic [RECIP_W-1:0] RECIP_360 = 26'd47721859;

    localparam logic [RULE_W-1:0] RULE_RESET = 2'd0;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'h0001_0000;

    localparam logic [CFG_ADDR_W-1:0] CFG_RULE_SELECT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE   = 1'b1;

    typedef enum logic [2:0] {
        SCL_IDLE,
        SCL_ABS,
        SCL_MUL_LO,
        SCL_MUL_HI,
        SCL_SUM,
        SCL_DIV,
        SCL_DONE
    } t_scl_state;

    typedef struct packed {
        logic valid;
        logic clip;
    } t_job_ctl;

endpackage

// File: sv/ncq_front.sv
// Sample intake: group tracking and weighted group sums.
module ncq_front #(
    parameter int SAMPLE_WIDTH = ncq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [ncq_pkg::RULE_W-1:0]                 i_rule,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]             i_sample,
    input  logic                                       i_last,
    input  logic                                       i_full,
    output logic                                       o_push,
    output logic signed [SAMPLE_WIDTH+ncq_pkg::WSUM_GROWTH-1:0] o_wsum,
    output logic                                       o_last
);
    import ncq_pkg::*;

    localparam int WSUM_W = SAMPLE_WIDTH + WSUM_GROWTH;

    logic signed [SAMPLE_WIDTH-1:0] r_smp [4];
    logic [2:0]                     r_pos;
    logic [2:0]                     n_pos;
    logic [2:0]                     rule_p1;
    logic [2:0]                     k;
    logic [2:0]                     npts;
    logic                           close_grp;
    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] op [5];

    // 360 times the Newton-Cotes weighted sum over n points
    function automatic logic signed [WSUM_W-1:0] f_weigh(
        input logic [2:0]                     n,
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b,
        input logic signed [SAMPLE_WIDTH-1:0] c,
        input logic signed [SAMPLE_WIDTH-1:0] d,
        input logic signed [SAMPLE_WIDTH-1:0] e
    );
        logic signed [WSUM_W-1:0] ea, eb, ec, ed, ee, t, u, r;
        ea = WSUM_W'(a);
        eb = WSUM_W'(b);
        ec = WSUM_W'(c);
        ed = WSUM_W'(d);
        ee = WSUM_W'(e);
        t  = '0;
        u  = '0;
        r  = '0;
        case (n)
            3'd2: begin
                t = ea + eb;
                r = (t <<< 7) + (t <<< 5) + (t <<< 4) + (t <<< 2);
            end
            3'd3: begin
                t = ea + (eb <<< 2) + ec;
                r = (t <<< 7) - (t <<< 3);
            end
            3'd4: begin
                u = eb + ec;
                t = ea + ed + (u <<< 1) + u;
                r = (t <<< 7) + (t <<< 3) - t;
            end
            3'd5: begin
                u = ea + ee;
                t = (u <<< 3) - u + ((eb + ed) <<< 5) + (ec <<< 3) + (ec <<< 2);
                r = t <<< 4;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign rule_p1   = 3'(i_rule) + 3'd1;
    assign close_grp = (r_pos >= rule_p1);
    // slot that the new sample takes in the weighed group
    assign k         = close_grp ? rule_p1 : r_pos;
    assign npts      = k + 3'd1;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            op[i] = (k == 3'(i)) ? i_sample : r_smp[i];
        end
        op[4] = i_sample;
    end

    assign o_push = accept && (close_grp || i_last);
    assign o_last = i_last;
    assign o_wsum = (close_grp || k != 3'd0) ? f_weigh(npts, op[0], op[1], op[2], op[3], op[4])
                                             : '0;

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_last) begin
                n_pos = 3'd0;
            end else if (close_grp) begin
                n_pos = 3'd1;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // held samples are only read below the fill position, so need no reset
    always_ff @(posedge i_clk) begin
        if (accept && !i_last) begin
            if (close_grp) begin
                r_smp[0] <= i_sample;
            end else begin
                r_smp[r_pos[1:0]] <= i_sample;
            end
        end
    end

endmodule

// File: sv/ncq_fifo.sv
// Short queue between the intake and the accumulator.
module ncq_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = ncq_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/ncq_accum.sv
// Saturating run accumulator; hands the closed total to the scaler.
module ncq_accum #(
    parameter int SAMPLE_WIDTH = ncq_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = ncq_pkg::ACC_WIDTH_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    input  logic signed [SAMPLE_WIDTH+ncq_pkg::WSUM_GROWTH-1:0] i_wsum,
    input  logic                                                i_last,
    output logic                                                o_pop,
    output ncq_pkg::t_job_ctl                                   o_job,
    output logic signed [ACC_WIDTH-1:0]                         o_job_acc,
    input  logic                                                i_job_ready
);
    import ncq_pkg::*;

    localparam int WSUM_W = SAMPLE_WIDTH + WSUM_GROWTH;
    localparam int SUM_W  = ((ACC_WIDTH > WSUM_W) ? ACC_WIDTH : WSUM_W) + 1;

    logic signed [ACC_WIDTH-1:0] r_acc, n_acc;
    logic                        r_clip, n_clip;
    logic signed [SUM_W-1:0]     sum;
    logic signed [ACC_WIDTH-1:0] sat;
    logic                        fits;

    assign sum  = SUM_W'(r_acc) + SUM_W'(i_wsum);
    // in range when every bit above the accumulator's sign agrees with it
    assign fits = (&sum[SUM_W-1:ACC_WIDTH-1]) || !(|sum[SUM_W-1:ACC_WIDTH-1]);
    assign sat  = fits ? sum[ACC_WIDTH-1:0]
                       : (sum[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                       : {1'b0, {(ACC_WIDTH-1){1'b1}}});

    assign o_pop       = i_valid && (!i_last || i_job_ready);
    assign o_job.valid = i_valid && i_last;
    assign o_job.clip  = r_clip || !fits;
    assign o_job_acc   = sat;

    always_comb begin
        n_acc  = r_acc;
        n_clip = r_clip;
        if (o_pop) begin
            if (i_last) begin
                n_acc  = '0;
                n_clip = 1'b0;
            end else begin
                n_acc  = sat;
                n_clip = r_clip || !fits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_clip <= n_clip;
        end
    end

endmodule

// File: sv/ncq_scale.sv
// Final scaling: total times step over 360, rounded, saturated, output register.
module ncq_scale #(
    parameter int ACC_WIDTH = ncq_pkg::ACC_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ncq_pkg::t_job_ctl                  i_job,
    input  logic signed [ACC_WIDTH-1:0]        i_job_acc,
    output logic                               o_job_ready,
    input  logic [ncq_pkg::STEP_W-1:0]         i_step,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ncq_pkg::OUT_WIDTH-1:0]      o_data,
    output logic                               o_flag
);
    import ncq_pkg::*;

    localparam int PROD_W    = ACC_WIDTH + STEP_W;
    localparam int DIV_W     = ((PROD_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W) * DIV_DIGIT_W;
    localparam int DIV_STEPS = DIV_W / DIV_DIGIT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PART_W    = REM_W + DIV_DIGIT_W;
    localparam int MULQ_W    = PART_W + RECIP_W;
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    t_scl_state r_state, n_state;

    logic [ACC_WIDTH-1:0]          r_acc;
    logic                          r_clip;
    logic                          r_neg;
    logic [ACC_WIDTH-1:0]          r_mag;
    logic [2*LIMB_W-1:0]           r_pp;
    logic [DIV_W-1:0]              r_num;
    logic [REM_W-1:0]              r_rem;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_out_valid;
    logic [OUT_WIDTH-1:0]          r_out_data;
    logic                          r_out_flag;

    logic                          mul_hi;
    logic                          out_free;
    logic                          out_load;
    logic [LIMB_W-1:0]             mul_a;
    logic [2*LIMB_W-1:0]           mul_p;
    logic [PART_W-1:0]             div_part;
    logic [MULQ_W-1:0]             div_prod;
    logic [DIV_DIGIT_W-1:0]        div_q;
    logic [PART_W-1:0]             div_back;
    logic [DIV_W-1:0]              div_num;
    logic [REM_W-1:0]              div_rem;
    logic                          over;
    logic [OUT_WIDTH-1:0]          res;

    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SCL_IDLE:   if (i_job.valid) n_state = SCL_ABS;
            SCL_ABS:    n_state = SCL_MUL_LO;
            SCL_MUL_LO: n_state = SCL_MUL_HI;
            SCL_MUL_HI: n_state = SCL_SUM;
            SCL_SUM:    n_state = SCL_DIV;
            SCL_DIV:    if (r_cnt == '0) n_state = SCL_DONE;
            SCL_DONE:   if (out_free) n_state = SCL_IDLE;
            default:    n_state = SCL_IDLE;
        endcase
    end

    // state decodes
    always_comb begin
        o_job_ready = 1'b0;
        mul_hi      = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            SCL_IDLE:   o_job_ready = 1'b1;
            SCL_MUL_HI: mul_hi      = 1'b1;
            SCL_DONE:   out_load    = out_free;
            default:    ;
        endcase
    end

    // one 32 by 32 multiplier, low limb then high limb
    assign mul_a = mul_hi ? LIMB_W'(r_mag[ACC_WIDTH-1:LIMB_W]) : r_mag[LIMB_W-1:0];
    assign mul_p = mul_a * i_step;

    // division by 360, one 16-bit quotient digit a cycle by reciprocal multiplication
    assign div_part = {r_rem, r_num[DIV_W-1 -: DIV_DIGIT_W]};
    assign div_prod = MULQ_W'(div_part) * MULQ_W'(RECIP_360);
    assign div_q    = div_prod[RECIP_SHIFT +: DIV_DIGIT_W];
    assign div_back = PART_W'(div_q) * PART_W'(SCALE_DEN);
    assign div_rem  = REM_W'(div_part - div_back);
    assign div_num  = {r_num[DIV_W-DIV_DIGIT_W-1:0], div_q};

    assign over = (|r_num[DIV_W-1:OUT_WIDTH])
               || (r_num[OUT_WIDTH-1] && (!r_neg || (|r_num[OUT_WIDTH-2:0])));
    assign res  = over  ? (r_neg ? OUT_MIN : OUT_MAX)
                : r_neg ? (~r_num[OUT_WIDTH-1:0] + 1'b1) : r_num[OUT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SCL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SCL_IDLE: begin
                if (i_job.valid) begin
                    r_acc  <= i_job_acc;
                    r_clip <= i_job.clip;
                end
            end
            SCL_ABS: begin
                r_neg <= r_acc[ACC_WIDTH-1];
                r_mag <= r_acc[ACC_WIDTH-1] ? (~r_acc + 1'b1) : r_acc;
            end
            SCL_MUL_LO: r_pp <= mul_p;
            SCL_MUL_HI: begin
                // rounding bias of half the divisor rides in with the low product
                r_num <= DIV_W'(r_pp) + DIV_W'(HALF_DEN);
                r_pp  <= mul_p;
            end
            SCL_SUM: begin
                r_num <= r_num + (DIV_W'(r_pp) << LIMB_W);
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end
            SCL_DIV: begin
                r_num <= div_num;
                r_rem <= div_rem;
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= res;
            r_out_flag <= over || r_clip;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_flag  = r_out_flag;

endmodule

// File: sv/newton_cotes_quadrature_core.sv
// Top level of the composite Newton-Cotes quadrature core.
//
//  port group   direction  payload (lowest bit first)
//  s_axis       in         tdata: sample_value; tlast: last_sample
//  m_axis       out        tdata: integral_value; tuser: saturated_flag
//  i_cfg_*      in         0 rule_select, 1 step_size
//
// Samples are taken one per cycle while the queue is not full; each group sum is weighed in
// the cycle its closing or last sample is taken and queued for the accumulator, four entries
// deep. At the last sample of a run the scaler takes the total: setup and a two-limb multiply
// by step_size, then division by 360 one 16-bit quotient digit at a time, and the output
// load; it takes no new total until then, so runs can back up into the queue while it is busy.
// Reset is synchronous, active low: clears the run, rule_select to 0, step_size to 1.0.
// The output register holds a result while m_axis_tready is low; the scaler then waits.
module newton_cotes_quadrature_core #(
    parameter int SAMPLE_WIDTH = ncq_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = ncq_pkg::ACC_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [ncq_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [ncq_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample_value
    input  logic                                  s_axis_tlast,  // last_sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ncq_pkg::OUT_WIDTH-1:0]         m_axis_tdata,  // integral_value
    output logic                                  m_axis_tuser   // saturated_flag
);
    import ncq_pkg::*;

    localparam int WSUM_W = SAMPLE_WIDTH + WSUM_GROWTH;
    localparam int ENTRY_W = WSUM_W + 1;

    logic [RULE_W-1:0]           r_rule;
    logic [STEP_W-1:0]           r_step;

    logic                        fifo_full;
    logic                        fifo_valid;
    logic                        push;
    logic                        pop;
    logic signed [WSUM_W-1:0]    push_wsum;
    logic                        push_last;
    logic [ENTRY_W-1:0]          fifo_out;
    t_job_ctl                    job;
    logic signed [ACC_WIDTH-1:0] job_acc;
    logic                        job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= RULE_RESET;
            r_step <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_RULE_SELECT: r_rule <= i_cfg_wdata[RULE_W-1:0];
                CFG_STEP_SIZE:   r_step <= i_cfg_wdata[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    ncq_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rule   (r_rule),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_last   (s_axis_tlast),
        .i_full   (fifo_full),
        .o_push   (push),
        .o_wsum   (push_wsum),
        .o_last   (push_last)
    );

    ncq_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_wsum, push_last}),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .i_pop   (pop),
        .o_data  (fifo_out)
    );

    ncq_accum #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fifo_valid),
        .i_wsum      ($signed(fifo_out[ENTRY_W-1:1])),
        .i_last      (fifo_out[0]),
        .o_pop       (pop),
        .o_job       (job),
        .o_job_acc   (job_acc),
        .i_job_ready (job_ready)
    );

    ncq_scale #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_acc   (job_acc),
        .o_job_ready (job_ready),
        .i_step      (r_step),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_flag      (m_axis_tuser)
    );

endmodule

// File: tb/sv/tb_newton_cotes_quadrature_core.sv
// Self-checking testbench of the Newton-Cotes quadrature core: directed and random sample runs.
`timescale 1ns / 1ps

module tb_newton_cotes_quadrature_core;
    import ncq_pkg::*;

    localparam logic [RULE_W-1:0] RULE_TRAPEZOID     = 2'd0;
    localparam logic [RULE_W-1:0] RULE_SIMPSON       = 2'd1;
    localparam logic [RULE_W-1:0] RULE_THREE_EIGHTHS = 2'd2;
    localparam logic [RULE_W-1:0] RULE_BOOLE         = 2'd3;

    localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [31:0] STEP_MAX   = 32'hFFFF_FFFF;

    localparam logic [63:0] OUT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] OUT_MIN = 64'h8000_0000_0000_0000;

    // queue, setup, multiply and division of the scaler, doubled for margin
    localparam int DRAIN_CYCLES = 2 * (ACC_WIDTH_DEF / 4 + 13 + FIFO_DEPTH);
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int MIN_RESULTS  = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [63:0] integral;
        logic        saturated;
    } t_integral_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_WIDTH-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    // register copies and run state of the predictor
    logic [RULE_W-1:0]  rule_setting = RULE_RESET;
    logic [STEP_W-1:0]  step_setting = STEP_RESET;
    logic signed [63:0] held_samples [4] = '{default: '0};
    int unsigned        held_count     = 0;
    logic signed [63:0] weighted_total = '0;
    bit                 total_clipped  = 1'b0;

    t_integral_result expected_integrals [$];

    int unsigned samples_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned burst_left      = 0;

    newton_cotes_quadrature_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sample_value
        .s_axis_tlast  (s_axis_tlast),   // last_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // integral_value
        .m_axis_tuser  (m_axis_tuser)    // saturated_flag
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic signed [63:0] weigh_group(input int unsigned n,
                                                       input logic signed [63:0] a, b, c, d, e);
        case (n)
            2:       return 180 * (a + b);
            3:       return 120 * (a + 4 * b + c);
            4:       return 135 * (a + 3 * b + 3 * c + d);
            5:       return 16 * (7 * a + 32 * b + 12 * c + 32 * d + 7 * e);
            default: return '0;
        endcase
    endfunction

    task automatic accumulate(input logic signed [63:0] term);
        logic [64:0] sum;
        sum = {weighted_total[63], weighted_total} + {term[63], term};
        if (sum[64] != sum[63]) begin
            weighted_total = sum[64] ? OUT_MIN : OUT_MAX;
            total_clipped  = 1'b1;
        end else begin
            weighted_total = sum[63:0];
        end
    endtask

    // total * step / 360, rounded half away from zero, clipped to 64 bits
    task automatic scale_integral(input logic signed [63:0] total, input logic [31:0] step,
                                  output t_integral_result res);
        logic        neg;
        logic [63:0] abs_total;
        logic [127:0] quot;
        neg       = total[63];
        abs_total = neg ? -total : total;
        quot      = ({64'd0, abs_total} * {96'd0, step} + 128'd180) / 128'd360;
        if (!neg && quot > {64'd0, OUT_MAX}) begin
            res.integral  = OUT_MAX;
            res.saturated = 1'b1;
        end else if (neg && quot > {64'd0, OUT_MIN}) begin
            res.integral  = OUT_MIN;
            res.saturated = 1'b1;
        end else begin
            res.integral  = neg ? -quot[63:0] : quot[63:0];
            res.saturated = 1'b0;
        end
    endtask

    task automatic integrate_sample(input logic [31:0] raw, input logic last);
        logic signed [63:0] x;
        logic signed [63:0] grp [5];
        int unsigned        group_len;
        t_integral_result   res;
        x         = {{32{raw[31]}}, raw};
        group_len = rule_setting;
        group_len = group_len + 2;
        if (held_count + 1 >= group_len) begin
            // close with the oldest held samples and this one; drop any extra held
            for (int i = 0; i < 4; i++)
                grp[i] = held_samples[i];
            grp[4]             = '0;
            grp[group_len - 1] = x;
            accumulate(weigh_group(group_len, grp[0], grp[1], grp[2], grp[3], grp[4]));
            held_samples[0] = x;
            held_count      = 1;
        end else begin
            held_samples[held_count] = x;
            held_count++;
        end
        if (last) begin
            // leftover tail of two to four samples is weighed by the rule for its own length
            if (held_count >= 2 && held_count <= 4)
                accumulate(weigh_group(held_count, held_samples[0], held_samples[1],
                                       held_samples[2], held_samples[3], '0));
            scale_integral(weighted_total, step_setting, res);
            res.saturated = res.saturated | total_clipped;
            expected_integrals.push_back(res);
            held_samples   = '{default: '0};
            held_count     = 0;
            weighted_total = '0;
            total_clipped  = 1'b0;
        end
    endtask

    // inputs change only at rising edges, so the falling edge sees settled handshakes
    always @(negedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            integrate_sample(s_axis_tdata, s_axis_tlast);
    end

    always @(negedge i_clk) begin : result_check
        t_integral_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (expected_integrals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected integral %h sat %0b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_integrals.pop_front();
                if (m_axis_tdata !== want.integral || m_axis_tuser !== want.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("integral mismatch: expected %h sat %0b, got %h sat %0b",
                                 want.integral, want.saturated, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    initial begin : result_stall
        int unsigned mode;
        int unsigned mode_left;
        int unsigned stall_left;
        mode_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left != 0) begin
                        m_axis_tready <= 1'b0;
                        stall_left--;
                    end else begin
                        m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 40);
                    end
                end
            endcase
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(negedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // called at a rising edge; returns at the edge that accepts the transfer
    task automatic send_sample(input logic [31:0] value, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(negedge i_clk);
        while (!s_axis_tready)
            @(negedge i_clk);
        @(posedge i_clk);
        samples_sent++;
    endtask

    // drop valid, let every expected result out, then let the queue and scaler settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_integrals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input bit write_rule, input logic [RULE_W-1:0] rule,
                              input bit write_step, input logic [STEP_W-1:0] step);
        if (write_rule) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= CFG_RULE_SELECT;
            i_cfg_wdata <= {{(CFG_DATA_W - RULE_W){1'b0}}, rule};
            @(posedge i_clk);
            rule_setting = rule;
        end
        if (write_step) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= CFG_STEP_SIZE;
            i_cfg_wdata <= step;
            @(posedge i_clk);
            step_setting = step;
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // reset values: trapezoid at unit step, extremes of the sample range
    task automatic test_default_config();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(ONE_Q16, 1'b1);
    endtask

    task automatic test_single_sample();
        wait_idle();
        set_config(1'b0, RULE_TRAPEZOID, 1'b1, '0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    // three minimum samples under Simpson at step 32768.0 land exactly on the lower bound
    task automatic test_exact_negative_bound();
        wait_idle();
        set_config(1'b1, RULE_SIMPSON, 1'b1, 32'h8000_0000);
        for (int i = 0; i < 3; i++)
            send_sample(SAMPLE_MIN, i == 2);
    endtask

    task automatic test_groups_and_tails();
        // Simpson group, trapezoid tail
        wait_idle();
        set_config(1'b1, RULE_SIMPSON, 1'b1, ONE_Q16);
        for (int i = 0; i < 4; i++)
            send_sample(ONE_Q16 * (i + 1), i == 3);
        // three-eighths group, Simpson tail
        wait_idle();
        set_config(1'b1, RULE_THREE_EIGHTHS, 1'b0, '0);
        for (int i = 0; i < 6; i++)
            send_sample($urandom(), i == 5);
        // Boole group, three-eighths tail, output clipped high
        wait_idle();
        set_config(1'b1, RULE_BOOLE, 1'b1, STEP_MAX);
        for (int i = 0; i < 8; i++)
            send_sample(SAMPLE_MAX, i == 7);
    endtask

    // hold three samples under Boole, then lower to trapezoid so the extras drop
    task automatic test_rule_change_mid_run();
        wait_idle();
        set_config(1'b1, RULE_BOOLE, 1'b1, ONE_Q16);
        for (int i = 0; i < 3; i++)
            send_sample($urandom_range(0, 32'h000F_FFFF), 1'b0);
        wait_idle();
        set_config(1'b1, RULE_TRAPEZOID, 1'b0, '0);
        send_sample(ONE_Q16, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_random_runs();
        int unsigned       start_count;
        int unsigned       run_len;
        int unsigned       switch_at;
        logic [STEP_W-1:0] step;
        logic [31:0]       value;
        start_count = samples_sent;
        while (samples_sent - start_count < RANDOM_ITEMS || results_checked < MIN_RESULTS) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       step = '0;
                1:       step = STEP_MAX;
                2, 3:    step = $urandom();
                default: step = $urandom_range(1, 32'h0004_0000);
            endcase
            set_config(1'b1, RULE_W'($urandom_range(RULE_TRAPEZOID, RULE_BOOLE)), 1'b1, step);
            repeat ($urandom_range(3, 8)) begin
                case ($urandom_range(0, 19))
                    0:               run_len = 1;
                    15, 16, 17, 18:  run_len = $urandom_range(25, 80);
                    19:              run_len = $urandom_range(150, 400);
                    default:         run_len = $urandom_range(2, 24);
                endcase
                switch_at = 0;
                if (run_len >= 3 && $urandom_range(0, 9) == 0)
                    switch_at = $urandom_range(1, run_len - 2);
                for (int unsigned i = 1; i <= run_len; i++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: value = $urandom();
                        4, 5, 6, 7: value = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                        8: begin
                            case ($urandom_range(0, 3))
                                0:       value = SAMPLE_MAX;
                                1:       value = SAMPLE_MIN;
                                2:       value = '0;
                                default: value = 32'hFFFF_FFFF;
                            endcase
                        end
                        default: value = $urandom_range(0, 32'h0000_01FF) - 32'h0000_0100;
                    endcase
                    send_sample(value, i == run_len);
                    if (i == switch_at) begin
                        wait_idle();
                        set_config(1'b1, RULE_W'($urandom_range(RULE_TRAPEZOID, RULE_BOOLE)),
                                   1'b0, '0);
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_config();
        test_single_sample();
        test_exact_negative_bound();
        test_groups_and_tails();
        test_rule_change_mid_run();
        test_random_runs();
        wait_idle();
        if (mismatch_count == 0 && expected_integrals.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
